>>> hdl/japanese_name_code_point_folder_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef JAPANESE_NAME_CODE_POINT_FOLDER_MACROS_SVH
`define JAPANESE_NAME_CODE_POINT_FOLDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JNCPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define JNCPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jncpf_pkg.sv
`default_nettype none

package jncpf_pkg;

    // Option registers, in register index order
    typedef struct packed {
        logic fold_width;
        logic drop_spaces;
        logic drop_symbols;
        logic hiragana_to_katakana;
        logic fold_kanji;
        logic fold_long_vowel;
    } t_cfg;

    // Register indexes
    typedef enum logic [2:0] {
        CFG_FOLD_WIDTH    = 3'd0,
        CFG_DROP_SPACES   = 3'd1,
        CFG_DROP_SYMBOLS  = 3'd2,
        CFG_HIRA_TO_KATA  = 3'd3,
        CFG_FOLD_KANJI    = 3'd4,
        CFG_FOLD_LONG     = 3'd5
    } t_cfg_index;

    // One result item
    typedef struct packed {
        logic [20:0] cp;
        logic        char_valid;
        logic        last;
    } t_res;

    // Results and held-kana update produced by one item
    typedef struct packed {
        logic [1:0]  cnt;
        t_res        e0;
        t_res        e1;
        logic        hold_set;
        logic [15:0] hold_kana;
    } t_fold_out;

endpackage

`default_nettype wire

>>> hdl/jncpf_fold.sv
`default_nettype none

module jncpf_fold
    import jncpf_pkg::*;
(
    input  wire logic [20:0] i_cp,
    input  wire logic        i_eot,
    input  wire logic        i_held_valid,
    input  wire logic [15:0] i_held_kana,
    input  wire t_cfg        i_cfg,
    output t_fold_out        o_fold
);

    localparam logic [15:0] WIDE_KANA [56] = '{
        16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5,
        16'h30E7, 16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9,
        16'h30BB, 16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA,
        16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8,
        16'h30DB, 16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6,
        16'h30E8, 16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3
    };

    localparam logic [15:0] KANJI_FROM [16] = '{
        16'h9AD9, 16'hFA11, 16'h6FF5, 16'h5D8B, 16'h5D8C, 16'h908A, 16'h9089, 16'h9F8D,
        16'h6AFB, 16'h570B, 16'h5B78, 16'h6FA4, 16'h9F4B, 16'h85DD, 16'h5713, 16'h9A5B
    };

    localparam logic [15:0] KANJI_TO [16] = '{
        16'h9AD8, 16'h5D0E, 16'h6D5C, 16'h5CF6, 16'h5CF6, 16'h8FBA, 16'h8FBA, 16'h7ADC,
        16'h685C, 16'h56FD, 16'h5B66, 16'h6CA2, 16'h658E, 16'h82B8, 16'h5186, 16'h99C5
    };

    localparam logic [15:0] PUNCT [14] = '{
        16'h30FB, 16'h002E, 16'hFF0E, 16'h002D, 16'hFF0D, 16'h2010, 16'h2212,
        16'h0027, 16'h2019, 16'h0022, 16'h201D, 16'h0026, 16'hFF06, 16'h00B7
    };

    localparam logic [20:0] CP_VOICED  = 21'h00FF9E;
    localparam logic [20:0] CP_SEMI    = 21'h00FF9F;
    localparam logic [20:0] FULL_LO    = 21'h00FF01;
    localparam logic [20:0] FULL_HI    = 21'h00FF5E;
    localparam logic [20:0] FULL_OFS   = 21'h00FEE0;
    localparam logic [20:0] HKANA_LO   = 21'h00FF66;
    localparam logic [20:0] HKANA_HI   = 21'h00FF9D;
    localparam logic [20:0] HIRA_LO    = 21'h003041;
    localparam logic [20:0] HIRA_HI    = 21'h003096;
    localparam logic [20:0] HIRA_OFS   = 21'h000060;
    localparam logic [20:0] LONG_MARK  = 21'h0030FC;
    localparam logic [20:0] SMALL_TSU  = 21'h0030C3;
    localparam logic [20:0] TSU        = 21'h0030C4;
    localparam logic [20:0] CASE_OFS   = 21'd32;

    typedef struct packed {
        logic        keep;
        logic [20:0] cp;
    } t_late;

    function automatic logic [15:0] wide_kana(input logic [5:0] idx);
        logic [15:0] v;
        v = 16'h0000;
        if (idx < 6'd56) begin
            v = WIDE_KANA[idx];
        end
        return v;
    endfunction

    // Drops, hiragana shift, old kanji, long vowel, upper case
    function automatic t_late late_fold(input logic [20:0] cp_in, input t_cfg cfg);
        logic [20:0] c;
        logic        drop;
        logic [20:0] k;
        t_late       r;
        c    = cp_in;
        drop = 1'b0;
        if (cfg.drop_spaces && (c == 21'h20 || c == 21'h3000 || c == 21'h09 ||
                                c == 21'h0A || c == 21'h0D)) begin
            drop = 1'b1;
        end
        if (cfg.drop_symbols) begin
            for (int i = 0; i < 14; i++) begin
                if (c == {5'd0, PUNCT[i]}) begin
                    drop = 1'b1;
                end
            end
        end
        if (cfg.hiragana_to_katakana && c >= HIRA_LO && c <= HIRA_HI) begin
            c = c + HIRA_OFS;
        end
        if (cfg.fold_kanji) begin
            // source forms are distinct, at most one matches
            k = c;
            for (int i = 0; i < 16; i++) begin
                if (c == {5'd0, KANJI_FROM[i]}) begin
                    k = {5'd0, KANJI_TO[i]};
                end
            end
            c = k;
        end
        if (cfg.fold_long_vowel) begin
            if (c == LONG_MARK) begin
                drop = 1'b1;
            end
            if (c == SMALL_TSU) begin
                c = TSU;
            end
        end
        if (c >= 21'h61 && c <= 21'h7A) begin
            c = c - CASE_OFS;
        end
        r.keep = !drop;
        r.cp   = c;
        return r;
    endfunction

    logic        is_merge;
    logic [20:0] merged;
    logic [20:0] held_cp;
    logic        w_full;
    logic        w_kana;
    logic [5:0]  kana_ofs;
    logic [20:0] cp_wide;
    t_late       late_merge;
    t_late       late_held;
    t_late       late_item;
    logic        a_v;
    logic        b_v;
    t_res        res_a;
    t_res        res_b;

    // Mark merge onto a held kana
    assign is_merge = i_held_valid && (i_cp == CP_VOICED || i_cp == CP_SEMI);
    assign merged   = {5'd0, i_held_kana} + ((i_cp == CP_VOICED) ? 21'd1 : 21'd2);
    assign held_cp  = {5'd0, i_held_kana};

    // Width fold
    assign w_full   = i_cfg.fold_width && i_cp >= FULL_LO && i_cp <= FULL_HI;
    assign w_kana   = i_cfg.fold_width && i_cp >= HKANA_LO && i_cp <= HKANA_HI;
    assign kana_ofs = 6'(i_cp - HKANA_LO);
    assign cp_wide  = w_full ? (i_cp - FULL_OFS)
                    : (w_kana ? {5'd0, wide_kana(kana_ofs)} : i_cp);

    assign late_merge = late_fold(merged, i_cfg);
    assign late_held  = late_fold(held_cp, i_cfg);
    assign late_item  = late_fold(cp_wide, i_cfg);

    // Held emission (a) and item result (b)
    always_comb begin
        a_v   = 1'b0;
        b_v   = 1'b0;
        res_a = '{cp: late_held.cp, char_valid: 1'b1, last: 1'b0};
        res_b = '{cp: 21'd0, char_valid: 1'b0, last: 1'b1};
        o_fold.hold_set  = 1'b0;
        o_fold.hold_kana = cp_wide[15:0];
        if (is_merge) begin
            b_v = late_merge.keep || i_eot;
            if (late_merge.keep) begin
                res_b = '{cp: late_merge.cp, char_valid: 1'b1, last: i_eot};
            end
        end else begin
            a_v = i_held_valid && late_held.keep;
            if (w_kana && !i_eot) begin
                o_fold.hold_set = 1'b1;
            end else begin
                b_v = late_item.keep || i_eot;
                if (late_item.keep) begin
                    res_b = '{cp: late_item.cp, char_valid: 1'b1, last: i_eot};
                end
            end
        end

        // Pack results in order
        o_fold.e1 = res_b;
        if (a_v) begin
            o_fold.e0  = res_a;
            o_fold.cnt = b_v ? 2'd2 : 2'd1;
        end else begin
            o_fold.e0  = res_b;
            o_fold.cnt = b_v ? 2'd1 : 2'd0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/jncpf_out_fifo.sv
`default_nettype none

module jncpf_out_fifo
    import jncpf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_res       i_e0,
    input  wire t_res       i_e1,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_res            o_head,
    output logic [1:0]      o_free
);

    t_res       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rptr];
    // a slot read out this cycle can be refilled this cycle
    assign o_free  = 2'd2 - r_count + {1'b0, i_pop};

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wptr] <= i_e0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[~r_wptr] <= i_e1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= r_wptr ^ i_push_cnt[0];
            r_rptr  <= r_rptr ^ i_pop;
            r_count <= r_count + i_push_cnt - {1'b0, i_pop};
        end
    end

endmodule

`default_nettype wire

>>> hdl/japanese_name_code_point_folder.sv
// An accepted item is registered and folded in the input register; its results
// enter the result queue when it fires, which waits for room in the queue.
// One item per cycle while the result queue has room for its results; an item with two
// results (a held kana plus its own character) needs both entries of the two-entry result queue.
// Reset (synchronous, active low): all option registers set, no kana held, input
// register and result queue empty.
`default_nettype none

module japanese_name_code_point_folder
    import jncpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_end_of_text,
    // result items
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [20:0]      o_out_code_point,
    output logic             o_char_valid,
    output logic             o_last_of_text,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic        i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        n_in_valid;
    logic [20:0] r_cp;
    logic        r_eot;
    logic        r_held_valid;
    logic [15:0] r_held_kana;

    t_fold_out   fold;
    logic [1:0]  free;
    logic        fire;
    logic        in_accept;
    logic        pop;
    t_res        head;

    // Option registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FOLD_WIDTH:   r_cfg.fold_width           <= i_cfg_data;
                CFG_DROP_SPACES:  r_cfg.drop_spaces          <= i_cfg_data;
                CFG_DROP_SYMBOLS: r_cfg.drop_symbols         <= i_cfg_data;
                CFG_HIRA_TO_KATA: r_cfg.hiragana_to_katakana <= i_cfg_data;
                CFG_FOLD_KANJI:   r_cfg.fold_kanji           <= i_cfg_data;
                CFG_FOLD_LONG:    r_cfg.fold_long_vowel      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register handshake
    assign fire       = r_in_valid && (fold.cnt <= free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cp  <= i_code_point;
            r_eot <= i_end_of_text;
        end
    end

    // Held kana, updated when an item is folded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_kana  <= 16'h0000;
        end else if (fire) begin
            r_held_valid <= fold.hold_set;
            r_held_kana  <= fold.hold_set ? fold.hold_kana : 16'h0000;
        end
    end

    jncpf_fold u_fold (
        .i_cp         (r_cp),
        .i_eot        (r_eot),
        .i_held_valid (r_held_valid),
        .i_held_kana  (r_held_kana),
        .i_cfg        (r_cfg),
        .o_fold       (fold)
    );

    // Result queue
    assign pop = o_out_valid && !i_out_stall;

    jncpf_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? fold.cnt : 2'd0),
        .i_e0       (fold.e0),
        .i_e1       (fold.e1),
        .i_pop      (pop),
        .o_valid    (o_out_valid),
        .o_head     (head),
        .o_free     (free)
    );

    assign o_out_code_point = head.cp;
    assign o_char_valid     = head.char_valid;
    assign o_last_of_text   = head.last;

    // Checks
    `include "japanese_name_code_point_folder_macros.svh"

    `JNCPF_ASSERT_IMP(a_held_range, r_held_valid,
        r_held_kana >= 16'h30A1 && r_held_kana <= 16'h30FC, "held kana out of range")
    `JNCPF_ASSERT_IMP(a_term_form, o_out_valid && !o_char_valid,
        o_out_code_point == 21'd0 && o_last_of_text, "malformed terminator")
    `JNCPF_ASSERT_NXT(a_stall_hold, r_in_valid && !fire,
        r_in_valid && $stable(r_cp) && $stable(r_eot), "stalled item lost")
    `JNCPF_ASSERT_IMP(a_no_overflow, fire, free >= fold.cnt && free <= 2'd2,
        "result queue overflow")

endmodule

`default_nettype wire

>>> test/jncpf_fold_checker.sv
`timescale 1ns / 1ps

module jncpf_fold_checker
    import jncpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [20:0] i_code_point,
    input  wire logic        i_end_of_text,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [20:0] i_out_code_point,
    input  wire logic        i_char_valid,
    input  wire logic        i_last_of_text,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic        i_cfg_data,
    output int               o_fail_cnt,
    output int               o_pending,
    output int               o_result_cnt,
    output int               o_term_cnt
);

    // Fold ranges and code points
    localparam logic [20:0] FW_FIRST   = 21'h0FF01;
    localparam logic [20:0] FW_LAST    = 21'h0FF5E;
    localparam logic [20:0] FW_OFFSET  = 21'h0FEE0;
    localparam logic [20:0] HK_FIRST   = 21'h0FF66;
    localparam logic [20:0] HK_LAST    = 21'h0FF9D;
    localparam logic [20:0] HW_VOICED  = 21'h0FF9E;
    localparam logic [20:0] HW_SEMI    = 21'h0FF9F;
    localparam logic [20:0] HIRA_FIRST = 21'h03041;
    localparam logic [20:0] HIRA_LAST  = 21'h03096;
    localparam logic [20:0] KATA_SHIFT = 21'h00060;
    localparam logic [20:0] LONG_VOWEL = 21'h030FC;
    localparam logic [20:0] SMALL_TSU  = 21'h030C3;
    localparam logic [20:0] TSU        = 21'h030C4;
    localparam logic [20:0] CASE_SHIFT = 21'd32;

    // Halfwidth kana 0xFF66..0xFF9D widened
    localparam logic [15:0] KANA_WIDE [56] = '{
        16'h30F2, 16'h30A1, 16'h30A3, 16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5,
        16'h30E7, 16'h30C3, 16'h30FC, 16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA,
        16'h30AB, 16'h30AD, 16'h30AF, 16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9,
        16'h30BB, 16'h30BD, 16'h30BF, 16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA,
        16'h30CB, 16'h30CC, 16'h30CD, 16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8,
        16'h30DB, 16'h30DE, 16'h30DF, 16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6,
        16'h30E8, 16'h30E9, 16'h30EA, 16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3
    };

    localparam logic [20:0] KANJI_SRC [16] = '{
        21'h09AD9, 21'h0FA11, 21'h06FF5, 21'h05D8B, 21'h05D8C, 21'h0908A, 21'h09089, 21'h09F8D,
        21'h06AFB, 21'h0570B, 21'h05B78, 21'h06FA4, 21'h09F4B, 21'h085DD, 21'h05713, 21'h09A5B
    };
    localparam logic [20:0] KANJI_DST [16] = '{
        21'h09AD8, 21'h05D0E, 21'h06D5C, 21'h05CF6, 21'h05CF6, 21'h08FBA, 21'h08FBA, 21'h07ADC,
        21'h0685C, 21'h056FD, 21'h05B66, 21'h06CA2, 21'h0658E, 21'h082B8, 21'h05186, 21'h099C5
    };

    localparam logic [20:0] SYMBOLS [14] = '{
        21'h030FB, 21'h0002E, 21'h0FF0E, 21'h0002D, 21'h0FF0D, 21'h02010, 21'h02212,
        21'h00027, 21'h02019, 21'h00022, 21'h0201D, 21'h00026, 21'h0FF06, 21'h000B7
    };

    typedef struct packed {
        logic        keep;
        logic [20:0] cp;
    } t_cp_fold;

    t_cfg        opts;
    logic        kana_held;
    logic [15:0] held_kana;
    t_res        folded_q [$];
    t_res        want;
    int          fail_cnt   = 0;
    int          pending    = 0;
    int          result_cnt = 0;
    int          term_cnt   = 0;

    assign o_fail_cnt   = fail_cnt;
    assign o_pending    = pending;
    assign o_result_cnt = result_cnt;
    assign o_term_cnt   = term_cnt;

    // Folds after widening; keep is low when the character is dropped
    function automatic t_cp_fold fold_late(input logic [20:0] cp_in);
        t_cp_fold    r;
        logic [20:0] cp;
        logic        hit;
        r.keep = 1'b1;
        cp     = cp_in;
        hit    = 1'b0;
        if (opts.drop_spaces && (cp == 21'h20 || cp == 21'h3000 || cp == 21'h09 ||
                                 cp == 21'h0A || cp == 21'h0D))
            r.keep = 1'b0;
        if (opts.drop_symbols)
            for (int k = 0; k < 14; k++)
                if (SYMBOLS[k] == cp) r.keep = 1'b0;
        if (opts.hiragana_to_katakana && cp >= HIRA_FIRST && cp <= HIRA_LAST)
            cp = cp + KATA_SHIFT;
        if (opts.fold_kanji)
            for (int k = 0; k < 16; k++)
                if (!hit && KANJI_SRC[k] == cp) begin
                    cp  = KANJI_DST[k];
                    hit = 1'b1;
                end
        if (opts.fold_long_vowel) begin
            if (cp == LONG_VOWEL) r.keep = 1'b0;
            if (cp == SMALL_TSU) cp = TSU;
        end
        if (cp >= 21'h61 && cp <= 21'h7A) cp = cp - CASE_SHIFT;
        r.cp = cp;
        return r;
    endfunction

    // Queue a character, or the empty terminator when an end item lost its character
    function automatic void queue_folded(input t_cp_fold f, input logic last);
        t_res entry;
        entry = '{cp: 21'd0, char_valid: 1'b0, last: 1'b1};
        if (f.keep)
            entry = '{cp: f.cp, char_valid: 1'b1, last: last};
        if (f.keep || last)
            folded_q.insert(folded_q.size(), entry);
    endfunction

    // Expected results of one accepted item
    function automatic void fold_item(input logic [20:0] cp_in, input logic eot);
        logic [20:0] cp;
        t_cp_fold    f;
        cp = cp_in;
        if (kana_held) begin
            kana_held = 1'b0;
            // voicing marks merge into the held kana whatever fold_width says now
            if (cp == HW_VOICED || cp == HW_SEMI) begin
                f = fold_late({5'd0, held_kana} + ((cp == HW_VOICED) ? 21'd1 : 21'd2));
                held_kana = '0;
                queue_folded(f, eot);
                return;
            end
            f = fold_late({5'd0, held_kana});
            if (f.keep) queue_folded(f, 1'b0);
            held_kana = '0;
        end
        if (opts.fold_width) begin
            if (cp >= FW_FIRST && cp <= FW_LAST) begin
                cp = cp - FW_OFFSET;
            end else if (cp >= HK_FIRST && cp <= HK_LAST) begin
                cp = {5'd0, KANA_WIDE[6'(cp - HK_FIRST)]};
                // hold it for a possible mark, unless the name ends here
                if (!eot) begin
                    held_kana = cp[15:0];
                    kana_held = 1'b1;
                    return;
                end
            end
        end
        queue_folded(fold_late(cp), eot);
    endfunction

    function automatic int field_bad(input string name, input logic [20:0] exp_v,
                                     input logic [20:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            opts      = '1;
            kana_held = 1'b0;
            held_kana = '0;
            folded_q.delete();
        end else begin
            // result side first; an item taken at this edge cannot be out yet
            if (i_out_valid && !i_out_stall) begin
                if (folded_q.size() == 0) begin
                    $error("result with nothing expected: out_code_point 0x%0h",
                           i_out_code_point);
                    fail_cnt++;
                end else begin
                    want = folded_q.pop_front();
                    if (field_bad("out_code_point", want.cp, i_out_code_point) +
                        field_bad("char_valid", 21'(want.char_valid), 21'(i_char_valid)) +
                        field_bad("last_of_text", 21'(want.last), 21'(i_last_of_text)) != 0)
                        fail_cnt++;
                    result_cnt++;
                    if (!want.char_valid) term_cnt++;
                end
            end
            // option writes; spare indexes are ignored
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FOLD_WIDTH:   opts.fold_width           = i_cfg_data;
                    CFG_DROP_SPACES:  opts.drop_spaces          = i_cfg_data;
                    CFG_DROP_SYMBOLS: opts.drop_symbols         = i_cfg_data;
                    CFG_HIRA_TO_KATA: opts.hiragana_to_katakana = i_cfg_data;
                    CFG_FOLD_KANJI:   opts.fold_kanji           = i_cfg_data;
                    CFG_FOLD_LONG:    opts.fold_long_vowel      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) fold_item(i_code_point, i_end_of_text);
        end
        pending = folded_q.size();
    end

endmodule

>>> test/tb_japanese_name_code_point_folder.sv
`timescale 1ns / 1ps

module tb_japanese_name_code_point_folder;
    import jncpf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 140;
    localparam int LONG_HOLD   = 120;
    localparam int SETTLE      = 8;

    // spare register indexes past the option list
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam logic [20:0] HALF_KANA_FIRST = 21'h0FF66;
    localparam logic [20:0] HALF_KANA_LAST  = 21'h0FF9D;
    localparam logic [20:0] MARK_VOICED     = 21'h0FF9E;
    localparam logic [20:0] MARK_SEMI       = 21'h0FF9F;

    // spaces, dropped symbols, old kanji, long vowel and tsu forms
    localparam logic [20:0] NOTABLE [38] = '{
        21'h00020, 21'h03000, 21'h00009, 21'h0000A, 21'h0000D,
        21'h030FB, 21'h0002E, 21'h0FF0E, 21'h0002D, 21'h0FF0D, 21'h02010, 21'h02212,
        21'h00027, 21'h02019, 21'h00022, 21'h0201D, 21'h00026, 21'h0FF06, 21'h000B7,
        21'h09AD9, 21'h0FA11, 21'h06FF5, 21'h05D8B, 21'h05D8C, 21'h0908A, 21'h09089,
        21'h09F8D, 21'h06AFB, 21'h0570B, 21'h05B78, 21'h06FA4, 21'h09F4B, 21'h085DD,
        21'h05713, 21'h09A5B, 21'h030FC, 21'h030C3, 21'h030C4
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [20:0] code_point;
    logic        end_of_text;
    logic        out_valid;
    logic        out_stall;
    logic [20:0] out_code_point;
    logic        char_valid;
    logic        last_of_text;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic        cfg_data;

    int   fail_cnt;
    int   pending;
    int   result_cnt;
    int   term_cnt;
    int   items_sent;
    int   settings_cnt;
    int   cycle_cnt;
    logic idling_on;
    logic hold_off_req;

    japanese_name_code_point_folder DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_code_point     (code_point),
        .i_end_of_text    (end_of_text),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_code_point (out_code_point),
        .o_char_valid     (char_valid),
        .o_last_of_text   (last_of_text),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    jncpf_fold_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_code_point     (code_point),
        .i_end_of_text    (end_of_text),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_code_point (out_code_point),
        .i_char_valid     (char_valid),
        .i_last_of_text   (last_of_text),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_cnt       (fail_cnt),
        .o_pending        (pending),
        .o_result_cnt     (result_cnt),
        .o_term_cnt       (term_cnt)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("japanese_name_code_point_folder regression: fail");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        int burst;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_off_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
                out_stall <= 1'b1;
                repeat (burst - 1) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item, maybe after an idle burst, and wait until it is taken
    task automatic push_item(input logic [20:0] cp, input logic eot);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        code_point  <= cp;
        end_of_text <= eot;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Stop offering and let every expected result drain out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
    endtask

    task automatic set_options(input t_cfg c, input logic with_spare);
        if (with_spare) begin
            write_reg(CFG_SPARE_LO, 1'b1);
            write_reg(CFG_SPARE_HI, 1'b0);
        end
        write_reg(CFG_FOLD_WIDTH,   c.fold_width);
        write_reg(CFG_DROP_SPACES,  c.drop_spaces);
        write_reg(CFG_DROP_SYMBOLS, c.drop_symbols);
        write_reg(CFG_HIRA_TO_KATA, c.hiragana_to_katakana);
        write_reg(CFG_FOLD_KANJI,   c.fold_kanji);
        write_reg(CFG_FOLD_LONG,    c.fold_long_vowel);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_cnt++;
    endtask

    // Code point drawn from the ranges the folds care about
    function automatic logic [20:0] pick_code_point();
        case ($urandom_range(0, 9))
            0:       return 21'($urandom);
            1:       return 21'($urandom_range(21'h0FF00, 21'h0FF65));
            2, 3:    return 21'($urandom_range(HALF_KANA_FIRST, HALF_KANA_LAST));
            4:       return $urandom_range(0, 1) ? MARK_VOICED : MARK_SEMI;
            5:       return 21'($urandom_range(21'h03040, 21'h03097));
            6:       return 21'($urandom_range(21'h030A0, 21'h030FF));
            7:       return NOTABLE[$urandom_range(0, 37)];
            8:       return 21'($urandom_range(0, 21'h7F));
            default: return 21'($urandom_range(21'h10FFF0, 21'h1FFFFF));
        endcase
    endfunction

    // One name: end mark only on its last item, halfwidth kana often voiced
    task automatic send_name();
        int          len;
        int          k;
        logic [20:0] cp;
        len = $urandom_range(1, 8);
        k   = 0;
        while (k < len) begin
            cp = pick_code_point();
            k++;
            push_item(cp, k == len);
            if (cp >= HALF_KANA_FIRST && cp <= HALF_KANA_LAST && k < len &&
                $urandom_range(0, 1) == 1) begin
                k++;
                push_item($urandom_range(0, 1) ? MARK_VOICED : MARK_SEMI, k == len);
            end
        end
    endtask

    initial begin
        t_cfg opts;
        int   phase_start;
        logic hold_done;
        logic pause_done;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        code_point   = '0;
        end_of_text  = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_FOLD_WIDTH;
        cfg_data     = 1'b0;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        items_sent   = 0;
        settings_cnt = 1;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed items under the reset options
        push_item(21'h0FF01, 1'b0);     // fullwidth ASCII, low end
        push_item(21'h0FF5E, 1'b0);     // fullwidth ASCII, high end
        push_item(21'h0FF41, 1'b0);     // fullwidth a, then upper-cased
        push_item(21'h0FF76, 1'b0);     // halfwidth ka held ...
        push_item(MARK_VOICED, 1'b0);   // ... voiced
        push_item(21'h0FF8A, 1'b0);     // halfwidth ha held ...
        push_item(MARK_SEMI, 1'b0);     // ... semi-voiced
        push_item(21'h0FF66, 1'b0);     // held kana flushed by a plain letter
        push_item(21'h0007A, 1'b0);
        push_item(MARK_VOICED, 1'b0);   // mark with nothing held
        push_item(21'h00020, 1'b0);
        push_item(21'h03000, 1'b0);
        push_item(21'h00009, 1'b0);
        push_item(21'h0000A, 1'b0);
        push_item(21'h0000D, 1'b1);     // dropped end item gives a terminator
        push_item(21'h030FB, 1'b0);
        push_item(21'h0FF0D, 1'b0);     // widened to hyphen, then dropped
        push_item(21'h03041, 1'b0);
        push_item(21'h03096, 1'b0);
        push_item(21'h09AD9, 1'b0);
        push_item(21'h030C3, 1'b0);
        push_item(21'h0FF70, 1'b0);     // held long vowel, dropped on flush
        push_item(21'h0FA11, 1'b0);
        push_item(21'h0FF73, 1'b0);
        push_item(MARK_VOICED, 1'b1);   // merge on the end item
        push_item(HALF_KANA_LAST, 1'b1); // kana on the end item is not held
        push_item(21'h1FFFFF, 1'b1);    // past the last code point
        push_item(21'h00000, 1'b1);
        push_item(21'h0FF76, 1'b0);     // stays held across the next option change

        // Random phases, each under its own options
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            if (phase == 0)
                opts = '0;
            else if (phase == 1)
                opts = '1;
            else
                opts = t_cfg'($urandom_range(0, 63));
            if (phase == PHASES - 1) idling_on = 1'b0;
            set_options(opts, phase == 0);
            if (phase == 0) push_item(MARK_VOICED, 1'b1);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (phase == 3 && !hold_done && items_sent - phase_start >= 40) begin
                    hold_off_req = 1'b1;
                    hold_done    = 1'b1;
                end
                if (phase == 5 && !pause_done && items_sent - phase_start >= 70) begin
                    wait_idle();
                    pause_done = 1'b1;
                end
                if ($urandom_range(0, 6) == 0)
                    push_item(pick_code_point(), 1'($urandom));
                else
                    send_name();
            end
        end
        wait_idle();

        $display("Checked %0d results (%0d empty terminators) from %0d input items",
                 result_cnt, term_cnt, items_sent);
        $display("over %0d option settings, with a long output hold-off and an input drain",
                 settings_cnt);
        if (fail_cnt == 0 && pending == 0)
            $display("japanese_name_code_point_folder regression: pass");
        else
            $display("japanese_name_code_point_folder regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/jncpf_pkg.sv
hdl/jncpf_fold.sv
hdl/jncpf_out_fifo.sv
hdl/japanese_name_code_point_folder.sv
test/jncpf_fold_checker.sv
test/tb_japanese_name_code_point_folder.sv
